// ===== rtl/core/qrgs_pkg.sv =====
package qrgs_pkg;

  localparam int MAX_ORDER  = 4;
  localparam int IDX_W      = $clog2(MAX_ORDER);
  localparam int AW         = 2 * IDX_W;
  localparam int DEPTH      = 2 ** AW;
  localparam int N_W        = $clog2(MAX_ORDER + 1);
  localparam int ORDER_W    = 3;
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 24;
  localparam int ACC_W      = 64;
  localparam int DIV_W      = DATA_W + FRAC_W;
  localparam int SQRT_STEPS = ACC_W / 2;
  localparam int CNT_W      = $clog2(DIV_W + 1);

  localparam logic [DATA_W-1:0] DATA_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    MAC_DOT,
    MAC_SQ,
    MAC_MUL
  } mac_op_e;

  typedef struct packed {
    logic    vld;
    logic    first;
    mac_op_e op;
  } mac_ctrl_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  // Q16.48 -> Q8.24, round half up, saturate to 32 bits
  function automatic logic [31:0] round_sat_f(input logic [63:0] v);
    logic [64:0] b;
    logic [40:0] s;
    b = {v[63], v} + 65'd8388608;
    s = 41'($signed(b) >>> FRAC_W);
    if (s[40:31] == {10{s[40]}}) begin
      return s[31:0];
    end
    return s[40] ? DATA_MIN : DATA_MAX;
  endfunction

  function automatic logic [31:0] sat33_f(input logic [32:0] d);
    if (d[32] != d[31]) begin
      return d[32] ? DATA_MIN : DATA_MAX;
    end
    return d[31:0];
  endfunction

endpackage

// ===== rtl/core/qrgs_in_if.sv =====
interface qrgs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

// ===== rtl/core/qrgs_out_if.sv =====
interface qrgs_out_if;
  logic               valid;
  logic               ready;
  logic               which_matrix;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [31:0] value;
  logic               singular;
  logic               final_res;

  modport source (output valid, output which_matrix, output row, output col,
                  output value, output singular, output final_res, input ready);
  modport sink   (input valid, input which_matrix, input row, input col,
                  input value, input singular, input final_res, output ready);
endinterface

// ===== rtl/core/qr_decomposition_gram_schmidt_core.sv =====
// QR factorization of an order-n matrix (n = 1..4, set by cfg_order_i, 0 acts as 1)
// by classical Gram-Schmidt in signed Q8.24. Feed the n*n elements row-major, one
// per input word; after the last one the core goes busy (in_i.ready low), factors
// the matrix and then emits n*n Q words followed by n*n R words, row-major, with
// singular set when a residual norm was zero (that Q column comes out zero) and
// final_res on the last word. One 32x32 multiplier with a 64-bit accumulator does
// all dot products, projections and squared norms; one bit-serial unit does the
// square roots (32 steps) and the per-element divides (56 steps). A 4x4 matrix
// spends most of its time from last element to last result in the 16 divides;
// loading accepts one element per cycle while in_i.valid is high. Writing the
// order register restarts loading.
module qr_decomposition_gram_schmidt_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_order_i,
  qrgs_in_if.sink              in_i,
  qrgs_out_if.source           out_o
);

  localparam int IW = qrgs_pkg::IDX_W;
  localparam int AW = qrgs_pkg::AW;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_UINIT = 4'd1;
  localparam logic [3:0] S_DOT   = 4'd2;
  localparam logic [3:0] S_DOTW  = 4'd3;
  localparam logic [3:0] S_RST   = 4'd4;
  localparam logic [3:0] S_PROJ  = 4'd5;
  localparam logic [3:0] S_PROJW = 4'd6;
  localparam logic [3:0] S_NORM  = 4'd7;
  localparam logic [3:0] S_NORMW = 4'd8;
  localparam logic [3:0] S_SQS   = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_DIVW  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]                       state_q, state_d;
  logic [qrgs_pkg::ORDER_W-1:0]     order_q;
  logic [qrgs_pkg::N_W-1:0]         n_eff;
  logic [IW-1:0]                    nm1;

  logic [IW-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, pk_q, pk_d;
  logic          pv_q, pv_d;
  logic          singular_q, singular_d;
  logic [31:0]   r_q, r_d, nrm_q, nrm_d;

  // matrix stores, one word per (row, col), fixed row stride
  logic [31:0]   a_mem [qrgs_pkg::DEPTH];
  logic [31:0]   q_mem [qrgs_pkg::DEPTH];
  logic [31:0]   r_mem [qrgs_pkg::DEPTH];
  logic [31:0]   u_q   [qrgs_pkg::MAX_ORDER];

  logic          a_we, q_we, r_we, u_we;
  logic [AW-1:0] a_waddr, q_waddr, r_waddr, q_raddr;
  logic [31:0]   q_wdata, r_wdata, u_wdata;
  logic [IW-1:0] u_addr;
  logic [31:0]   a_rd, q_rd, r_rd, u_rd;
  logic [31:0]   mac_rnd, u_wdata_p;

  qrgs_pkg::mac_ctrl_t  mac_ctrl;
  logic signed [31:0]   mac_a, mac_b;
  logic [63:0]          mac_prod, mac_acc;
  qrgs_pkg::iter_ctrl_t it_ctrl;
  qrgs_pkg::iter_stat_t it_stat;
  logic [31:0]          it_res;

  // output register
  logic          out_valid_q, out_valid_d, out_load;
  logic          o_which_q, o_sing_q, o_final_q;
  logic [1:0]    o_row_q, o_col_q;
  logic [31:0]   o_val_q;
  logic          om_q, om_d;
  logic [IW-1:0] orow_q, orow_d, ocol_q, ocol_d;
  logic          o_last;
  logic [31:0]   o_val;

  logic          in_fire;

  // effective order, clamped
  always_comb begin
    if (order_q == '0) begin
      n_eff = qrgs_pkg::N_W'(1);
    end else if (int'(order_q) > qrgs_pkg::MAX_ORDER) begin
      n_eff = qrgs_pkg::N_W'(qrgs_pkg::MAX_ORDER);
    end else begin
      n_eff = qrgs_pkg::N_W'(order_q);
    end
    nm1 = IW'(n_eff - qrgs_pkg::N_W'(1));
  end

  assign in_fire = in_i.valid && in_i.ready;
  assign u_addr  = pv_q ? pk_q : k_q;
  assign q_raddr = (state_q == S_OUT) ? {orow_q, ocol_q} : {k_q, j_q};
  assign a_rd    = a_mem[{k_q, i_q}];
  assign q_rd    = q_mem[q_raddr];
  assign r_rd    = r_mem[{orow_q, ocol_q}];
  assign u_rd    = u_q[u_addr];

  assign o_last  = om_q && (orow_q == nm1) && (ocol_q == nm1);
  assign o_val   = om_q ? ((orow_q > ocol_q) ? '0 : r_rd) : q_rd;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // shared multiplier operands
  always_comb begin
    mac_a = $signed(u_rd);
    mac_b = $signed(u_rd);
    case (state_q)
      S_DOT: begin
        mac_a = $signed(q_rd);
        mac_b = $signed(a_rd);
      end
      S_PROJ: begin
        mac_a = $signed(r_q);
        mac_b = $signed(q_rd);
      end
      default: ;
    endcase
  end

  qrgs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (mac_prod),
    .acc_o  (mac_acc)
  );

  qrgs_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (it_ctrl),
    .sq_i   (mac_acc),
    .num_i  ($signed(u_rd)),
    .den_i  (nrm_q[30:0]),
    .stat_o (it_stat),
    .res_o  (it_res)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    ld_row_d   = ld_row_q;
    ld_col_d   = ld_col_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    pk_d       = k_q;
    pv_d       = 1'b0;
    singular_d = singular_q;
    r_d        = r_q;
    nrm_d      = nrm_q;
    om_d       = om_q;
    orow_d     = orow_q;
    ocol_d     = ocol_q;
    mac_ctrl   = '0;
    mac_ctrl.op = qrgs_pkg::MAC_MUL;
    it_ctrl    = '0;
    a_we = 1'b0; a_waddr = {ld_row_q, ld_col_q};
    q_we = 1'b0; q_waddr = {k_q, i_q}; q_wdata = it_res;
    r_we = 1'b0; r_waddr = {j_q, i_q}; r_wdata = qrgs_pkg::round_sat_f(mac_acc);
    u_we = 1'b0; u_wdata = a_rd;

    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          a_we = 1'b1;
          if (ld_col_q == nm1) begin
            ld_col_d = '0;
            if (ld_row_q == nm1) begin
              ld_row_d   = '0;
              i_d        = '0;
              k_d        = '0;
              singular_d = 1'b0;
              state_d    = S_UINIT;
            end else begin
              ld_row_d = ld_row_q + 1'b1;
            end
          end else begin
            ld_col_d = ld_col_q + 1'b1;
          end
        end
      end
      S_UINIT: begin
        u_we = 1'b1;
        k_d  = k_q + 1'b1;
        if (k_q == nm1) begin
          k_d     = '0;
          j_d     = '0;
          state_d = (i_q == '0) ? S_NORM : S_DOT;
        end
      end
      S_DOT: begin
        mac_ctrl.vld   = 1'b1;
        mac_ctrl.first = (k_q == '0);
        mac_ctrl.op    = qrgs_pkg::MAC_DOT;
        k_d = k_q + 1'b1;
        if (k_q == nm1) begin
          k_d     = '0;
          state_d = S_DOTW;
        end
      end
      S_DOTW: state_d = S_RST;
      S_RST: begin
        r_d     = qrgs_pkg::round_sat_f(mac_acc);
        r_we    = 1'b1;
        state_d = S_PROJ;
      end
      S_PROJ: begin
        mac_ctrl.vld = 1'b1;
        pv_d = 1'b1;
        k_d  = k_q + 1'b1;
        if (k_q == nm1) begin
          k_d     = '0;
          state_d = S_PROJW;
        end
      end
      S_PROJW: begin
        if (j_q == i_q - 1'b1) begin
          state_d = S_NORM;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_DOT;
        end
      end
      S_NORM: begin
        mac_ctrl.vld   = 1'b1;
        mac_ctrl.first = (k_q == '0);
        mac_ctrl.op    = qrgs_pkg::MAC_SQ;
        k_d = k_q + 1'b1;
        if (k_q == nm1) begin
          k_d     = '0;
          state_d = S_NORMW;
        end
      end
      S_NORMW: state_d = S_SQS;
      S_SQS: begin
        it_ctrl.start = 1'b1;
        state_d       = S_SQRT;
      end
      S_SQRT: begin
        if (it_stat.done) begin
          nrm_d   = it_res;
          r_we    = 1'b1;
          r_waddr = {i_q, i_q};
          r_wdata = it_res;
          if (it_res == '0) begin
            singular_d = 1'b1;
          end
          state_d = S_DIV;
        end
      end
      S_DIV, S_DIVW: begin
        if (state_q == S_DIV && nrm_q != '0) begin
          it_ctrl.start  = 1'b1;
          it_ctrl.is_div = 1'b1;
          state_d        = S_DIVW;
        end else if (state_q == S_DIV || it_stat.done) begin
          q_we    = 1'b1;
          q_wdata = (nrm_q == '0) ? '0 : it_res;
          state_d = S_DIV;
          k_d     = k_q + 1'b1;
          if (k_q == nm1) begin
            k_d = '0;
            if (i_q == nm1) begin
              om_d    = 1'b0;
              orow_d  = '0;
              ocol_d  = '0;
              state_d = S_OUT;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = S_UINIT;
            end
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          ocol_d = ocol_q + 1'b1;
          if (ocol_q == nm1) begin
            ocol_d = '0;
            orow_d = orow_q + 1'b1;
            if (orow_q == nm1) begin
              orow_d = '0;
              om_d   = 1'b1;
            end
          end
          if (o_last) begin
            state_d = S_LOAD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase

    if (cfg_we_i) begin
      ld_row_d = '0;
      ld_col_d = '0;
    end
  end

  // projection write-back, in the cycle after the multiply
  always_comb begin
    if (pv_q) begin
      u_wdata_p = qrgs_pkg::sat33_f({u_rd[31], u_rd} -
                  {mac_rnd[31], mac_rnd});
    end else begin
      u_wdata_p = u_rd;
    end
  end

  assign mac_rnd = qrgs_pkg::round_sat_f(mac_prod);

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      order_q     <= 3'd4;
      ld_row_q    <= '0;
      ld_col_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      pk_q        <= '0;
      pv_q        <= 1'b0;
      singular_q  <= 1'b0;
      om_q        <= 1'b0;
      orow_q      <= '0;
      ocol_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        order_q <= cfg_order_i;
      end
      ld_row_q    <= ld_row_d;
      ld_col_q    <= ld_col_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      pk_q        <= pk_d;
      pv_q        <= pv_d;
      singular_q  <= singular_d;
      om_q        <= om_d;
      orow_q      <= orow_d;
      ocol_q      <= ocol_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath and stores
  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    nrm_q <= nrm_d;
    if (a_we) begin
      a_mem[a_waddr] <= in_i.element;
    end
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (r_we) begin
      r_mem[r_waddr] <= r_wdata;
    end
    if (u_we) begin
      u_q[k_q] <= u_wdata;
    end else if (pv_q) begin
      u_q[pk_q] <= u_wdata_p;
    end
    if (out_load) begin
      o_which_q <= om_q;
      o_row_q   <= 2'(orow_q);
      o_col_q   <= 2'(ocol_q);
      o_val_q   <= o_val;
      o_sing_q  <= singular_q;
      o_final_q <= o_last;
    end
  end

  assign in_i.ready         = (state_q == S_LOAD);
  assign out_o.valid        = out_valid_q;
  assign out_o.which_matrix = o_which_q;
  assign out_o.row          = o_row_q;
  assign out_o.col          = o_col_q;
  assign out_o.value        = $signed(o_val_q);
  assign out_o.singular     = o_sing_q;
  assign out_o.final_res    = o_final_q;

  // the bit-serial unit is only started when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_ctrl.start |-> !it_stat.busy)
    else $error("iter unit restarted while busy");

  // once the last word sits in the output register the sequencer has left S_OUT
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_final_q) |-> (state_q != S_OUT))
    else $error("emission continued past final word");

  // load position never runs past the active order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (ld_row_q <= nm1 && ld_col_q <= nm1))
    else $error("load index beyond order");

  // a done pulse only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_stat.done |-> $past(it_stat.busy))
    else $error("iter done without work");

endmodule

// ===== rtl/core/qrgs_mac.sv =====
// Shared 32x32 multiplier with a registered product and a 64-bit accumulator.
module qrgs_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qrgs_pkg::mac_ctrl_t       ctrl_i,
  input  logic signed [31:0]        a_i,
  input  logic signed [31:0]        b_i,
  output logic [63:0]               prod_o,
  output logic [63:0]               acc_o
);

  qrgs_pkg::mac_ctrl_t ctrl_q;
  logic [63:0]         prod_q;
  logic [63:0]         acc_q, acc_d;
  logic [63:0]         base;
  logic [64:0]         sum_s, sum_u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i * b_i);
    acc_q  <= acc_d;
  end

  always_comb begin
    base  = ctrl_q.first ? '0 : acc_q;
    sum_s = {base[63], base} + {prod_q[63], prod_q};
    sum_u = {1'b0, base} + {1'b0, prod_q};
    acc_d = acc_q;
    if (ctrl_q.vld) begin
      case (ctrl_q.op)
        qrgs_pkg::MAC_DOT: begin
          if (sum_s[64] != sum_s[63]) begin
            acc_d = sum_s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          end else begin
            acc_d = sum_s[63:0];
          end
        end
        qrgs_pkg::MAC_SQ: begin
          acc_d = sum_u[64] ? '1 : sum_u[63:0];
        end
        default: acc_d = acc_q;
      endcase
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

// ===== rtl/core/qrgs_iter.sv =====
// Bit-serial unit: integer square root (two bits per step) or restoring divide.
module qrgs_iter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qrgs_pkg::iter_ctrl_t   ctrl_i,
  input  logic [63:0]            sq_i,
  input  logic signed [31:0]     num_i,
  input  logic [30:0]            den_i,
  output qrgs_pkg::iter_stat_t   stat_o,
  output logic [31:0]            res_o
);

  logic                             busy_q, done_q, is_div_q, neg_q;
  logic [qrgs_pkg::CNT_W-1:0]       cnt_q;
  logic [63:0]                      x_q, y_q, bit_q;
  logic [31:0]                      rem_q;
  logic [30:0]                      den_q;
  logic [32:0]                      mag;
  logic [63:0]                      sq_t;
  logic [31:0]                      trial;
  logic                             last;
  logic [qrgs_pkg::DIV_W-1:0]       quo;

  always_comb begin
    mag   = num_i[31] ? (33'd0 - {num_i[31], num_i}) : {1'b0, num_i};
    sq_t  = y_q + bit_q;
    trial = {rem_q[30:0], x_q[qrgs_pkg::DIV_W-1]};
    last  = is_div_q ? (cnt_q == qrgs_pkg::CNT_W'(qrgs_pkg::DIV_W - 1))
                     : (cnt_q == qrgs_pkg::CNT_W'(qrgs_pkg::SQRT_STEPS - 1));
    quo   = y_q[qrgs_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      is_div_q <= ctrl_i.is_div;
      neg_q    <= num_i[31];
      den_q    <= den_i;
      cnt_q    <= '0;
      y_q      <= '0;
      rem_q    <= '0;
      bit_q    <= 64'h4000_0000_0000_0000;
      if (ctrl_i.is_div) begin
        x_q <= 64'({mag[31:0], 24'd0}) + 64'(den_i >> 1);
      end else begin
        x_q <= sq_i;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (is_div_q) begin
        x_q <= {x_q[62:0], 1'b0};
        if (trial >= {1'b0, den_q}) begin
          rem_q <= trial - {1'b0, den_q};
          y_q   <= {y_q[62:0], 1'b1};
        end else begin
          rem_q <= trial;
          y_q   <= {y_q[62:0], 1'b0};
        end
      end else begin
        bit_q <= bit_q >> 2;
        if (x_q >= sq_t) begin
          x_q <= x_q - sq_t;
          y_q <= (y_q >> 1) + bit_q;
        end else begin
          y_q <= y_q >> 1;
        end
      end
    end
  end

  always_comb begin
    if (!is_div_q) begin
      res_o = (y_q[63:31] != '0) ? qrgs_pkg::DATA_MAX : y_q[31:0];
    end else if (!neg_q) begin
      res_o = (quo[qrgs_pkg::DIV_W-1:31] != '0) ? qrgs_pkg::DATA_MAX : quo[31:0];
    end else if ((quo[qrgs_pkg::DIV_W-1:32] != '0) || (quo[31] && (quo[30:0] != '0))) begin
      res_o = qrgs_pkg::DATA_MIN;
    end else begin
      res_o = 32'd0 - quo[31:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
